// ===== sv/clx_pkg.sv =====
// Shared types, character constants and character class functions for the
// command line lexer. No dependencies.
package clx_pkg;

    localparam int MaxRes = 3;

    typedef logic [7:0] t_char;
    typedef logic [1:0] t_count;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        TT_IDENT  = 3'd0,
        TT_NUMBER = 3'd1,
        TT_STRING = 3'd2,
        TT_PATH   = 3'd3,
        TT_DASH   = 3'd4,
        TT_EQUALS = 3'd5
    } t_ttype;

    typedef struct packed {
        t_kind  kind;
        t_char  ch;
        t_ttype tt;
    } t_result;

    // All results caused by one character, in order, before serialization.
    typedef struct packed {
        t_count               cnt;
        t_result [MaxRes-1:0] res;
    } t_lex_out;

    localparam t_char CH_NUL    = 8'h00;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_CR     = 8'h0D;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_QUOTE  = 8'h22;
    localparam t_char CH_STAR   = 8'h2A;
    localparam t_char CH_DASH   = 8'h2D;
    localparam t_char CH_DOT    = 8'h2E;
    localparam t_char CH_SLASH  = 8'h2F;
    localparam t_char CH_ZERO   = 8'h30;
    localparam t_char CH_NINE   = 8'h39;
    localparam t_char CH_EQ     = 8'h3D;
    localparam t_char CH_QUEST  = 8'h3F;
    localparam t_char CH_UP_A   = 8'h41;
    localparam t_char CH_UP_Z   = 8'h5A;
    localparam t_char CH_USCORE = 8'h5F;
    localparam t_char CH_LO_A   = 8'h61;
    localparam t_char CH_LO_Z   = 8'h7A;
    localparam t_char CaseDelta = 8'h20;

    function automatic logic is_upper(input t_char c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic is_letter(input t_char c);
        return is_upper(c) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

    function automatic logic is_digit(input t_char c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input t_char c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_char to_lower(input t_char c);
        return is_upper(c) ? t_char'(c + CaseDelta) : c;
    endfunction

    function automatic t_result mk_result(input t_kind k, input t_char c, input t_ttype t);
        t_result r;
        r.kind = k;
        r.ch   = c;
        r.tt   = t;
        return r;
    endfunction

endpackage

// ===== sv/clx_in_if.sv =====
// Input channel of the command line lexer: one character item per handshake.
// No dependencies.
interface clx_in_if;
    logic       valid;
    logic       ready;
    logic       first_char;
    logic [7:0] char_code;

    modport source (output valid, output first_char, output char_code, input ready);
    modport sink   (input valid, input first_char, input char_code, output ready);
endinterface

// ===== sv/clx_out_if.sv =====
// Output channel of the command line lexer: one result item per handshake.
// No dependencies.
interface clx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] char_out;
    logic [2:0] token_type;
    logic       last_result;

    modport source (output valid, output result_kind, output char_out,
                    output token_type, output last_result, input ready);
    modport sink   (input valid, input result_kind, input char_out,
                    input token_type, input last_result, output ready);
endinterface

// ===== sv/clx_core.sv =====
// Lexer mode register and the combinational decode of one character into up
// to three results. Depends on clx_pkg.
module clx_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_first_char,
    input  clx_pkg::t_char    i_char_code,
    output clx_pkg::t_lex_out o_lex
);
    import clx_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_INT   = 3'd2,
        MODE_FRAC  = 3'd3,
        MODE_STR   = 3'd4,
        MODE_PATH  = 3'd5,
        MODE_DASH  = 3'd6
    } t_mode;

    t_mode   r_mode;
    t_mode   n_mode;
    t_mode   eff_mode;
    t_mode   id_mode;
    t_count  id_n;
    t_result id0;
    t_result id1;
    logic    pre_v;
    t_result pre;
    logic    own_v;
    t_result own;
    logic    use_idle;
    t_count  sec_n;
    t_result sec0;
    t_result sec1;
    t_char   c;

    assign c        = i_char_code;
    assign eff_mode = i_first_char ? MODE_IDLE : r_mode;

    // How the character is handled in idle mode, either directly or after a
    // token it terminates has been completed.
    always_comb begin
        id_mode = MODE_IDLE;
        id_n    = 2'd0;
        id0     = mk_result(KIND_CHAR, c, TT_IDENT);
        id1     = mk_result(KIND_CHAR, c, TT_IDENT);
        if (is_letter(c) || (c == CH_STAR) || (c == CH_QUEST)) begin
            id_mode = MODE_IDENT;
            id_n    = 2'd1;
            id0.ch  = to_lower(c);
        end else if (is_digit(c)) begin
            id_mode = MODE_INT;
            id_n    = 2'd1;
        end else if (c == CH_QUOTE) begin
            id_mode = MODE_STR;
        end else if ((c == CH_SLASH) || (c == CH_DOT)) begin
            id_mode = MODE_PATH;
            id_n    = 2'd1;
        end else if (is_space(c)) begin
            id_mode = MODE_IDLE;
        end else if (c == CH_DASH) begin
            id_mode = MODE_DASH;
            id_n    = 2'd1;
        end else if (c == CH_EQ) begin
            id_n = 2'd2;
            id1  = mk_result(KIND_DONE, CH_NUL, TT_EQUALS);
        end else begin
            id0  = mk_result(KIND_ERR, c, TT_IDENT);
            id_n = 2'd1;
        end
    end

    // Per-mode handling: an optional completion first, then either at most one own
    // character result or the idle handling of the same character.
    always_comb begin
        n_mode   = eff_mode;
        pre_v    = 1'b0;
        pre      = mk_result(KIND_DONE, CH_NUL, TT_IDENT);
        own_v    = 1'b0;
        own      = mk_result(KIND_CHAR, c, TT_IDENT);
        use_idle = 1'b0;
        case (eff_mode)
            MODE_IDENT: begin
                if (is_letter(c) || is_digit(c) || (c == CH_USCORE) || (c == CH_DOT)
                    || (c == CH_STAR)) begin
                    own_v  = 1'b1;
                    own.ch = to_lower(c);
                end else begin
                    pre_v    = 1'b1;
                    use_idle = 1'b1;
                end
            end
            MODE_INT: begin
                if (is_digit(c)) begin
                    own_v = 1'b1;
                end else if (c == CH_DOT) begin
                    own_v  = 1'b1;
                    n_mode = MODE_FRAC;
                end else if (is_letter(c)) begin
                    own_v  = 1'b1;
                    n_mode = MODE_IDENT;
                end else begin
                    pre_v    = 1'b1;
                    pre.tt   = TT_NUMBER;
                    use_idle = 1'b1;
                end
            end
            MODE_FRAC: begin
                if (is_digit(c)) begin
                    own_v = 1'b1;
                end else begin
                    pre_v    = 1'b1;
                    pre.tt   = TT_NUMBER;
                    use_idle = 1'b1;
                end
            end
            MODE_STR: begin
                if (c != CH_QUOTE) begin
                    own_v = 1'b1;
                end else begin
                    pre_v  = 1'b1;
                    pre.tt = TT_STRING;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_PATH: begin
                if (!is_space(c)) begin
                    own_v = 1'b1;
                end else begin
                    pre_v  = 1'b1;
                    pre.tt = TT_PATH;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_DASH: begin
                if (is_digit(c)) begin
                    own_v  = 1'b1;
                    n_mode = MODE_INT;
                end else if (is_letter(c)) begin
                    pre_v    = 1'b1;
                    pre.tt   = TT_DASH;
                    use_idle = 1'b1;
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase

        if (use_idle) begin
            n_mode = id_mode;
            sec_n  = id_n;
            sec0   = id0;
            sec1   = id1;
        end else begin
            sec_n = own_v ? 2'd1 : 2'd0;
            sec0  = own;
            sec1  = own;
        end

        if (pre_v) begin
            o_lex.cnt    = t_count'(sec_n + 2'd1);
            o_lex.res[0] = pre;
            o_lex.res[1] = sec0;
            o_lex.res[2] = sec1;
        end else begin
            o_lex.cnt    = sec_n;
            o_lex.res[0] = sec0;
            o_lex.res[1] = sec1;
            o_lex.res[2] = sec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (i_load) begin
            r_mode <= n_mode;
        end
    end

endmodule

// ===== sv/clx_outbuf.sv =====
// Result register that holds all results of one character and hands them
// out one per handshake. Depends on clx_pkg.
module clx_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clx_pkg::t_lex_out i_lex,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_load,
    output logic              o_valid,
    input  logic              i_ready,
    output clx_pkg::t_kind    o_kind,
    output clx_pkg::t_char    o_char,
    output clx_pkg::t_ttype   o_ttype,
    output logic              o_last
);
    import clx_pkg::*;

    t_result [MaxRes-1:0] r_res;
    t_count               r_cnt;
    t_count               r_idx;
    t_result              cur;
    logic                 last;
    logic                 fire_out;

    always_comb begin
        case (r_idx)
            2'd0:    cur = r_res[0];
            2'd1:    cur = r_res[1];
            2'd2:    cur = r_res[2];
            default: cur = r_res[0];
        endcase
    end

    assign last       = (r_idx == t_count'(r_cnt - 2'd1));
    assign o_valid    = (r_cnt != 2'd0);
    assign fire_out   = o_valid && i_ready;
    assign o_in_ready = (r_cnt == 2'd0) || (fire_out && last);
    assign o_load     = i_in_valid && o_in_ready;

    assign o_kind  = cur.kind;
    assign o_char  = cur.ch;
    assign o_ttype = cur.tt;
    assign o_last  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (o_load) begin
            r_cnt <= i_lex.cnt;
            r_idx <= 2'd0;
        end else if (fire_out) begin
            if (last) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= t_count'(r_idx + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_res <= i_lex.res;
        end
    end

endmodule

// ===== sv/command_line_lexer.sv =====
// Top level of the command line lexer: mode decode plus result serializer.
// Depends on clx_pkg, clx_in_if, clx_out_if, clx_core and clx_outbuf.
//
// Usage:
// The input channel i_in carries one character per item, with first_char set
// on the first character of each command; that flag returns the lexer to idle
// mode before the character is decoded. The host appends a trailing space so
// that the last token of a line is completed.
// The output channel o_out carries one result per item: a token character, a
// token completion with its type, or a lexical error. One input character
// causes zero to three results; last_result marks the final one of them.
// A character is decoded in the cycle it is accepted and all of its results
// are written into the result register at that edge, so the first result is
// offered in the cycle after acceptance. The results are then handed out one per
// cycle while o_out.ready is high.
// Throughput: a character that causes zero results is taken every cycle, one
// with one result every cycle while o_out.ready is high; one with more results
// is held until its last result is taken, when the next character is accepted.
// If the receiver stalls, the current result holds and input stalls once the
// result register is full. Reset returns the lexer to idle mode and discards
// any pending results. Characters of a token that is never completed must be
// dropped by the consumer.
module command_line_lexer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    clx_in_if.sink           i_in,
    clx_out_if.source        o_out
);
    import clx_pkg::*;

    t_lex_out lex;
    logic     load;
    t_kind    kind;
    t_char    ch;
    t_ttype   ttype;

    // Decode of the incoming character against the current lexer mode.
    clx_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_first_char (i_in.first_char),
        .i_char_code  (i_in.char_code),
        .o_lex        (lex)
    );

    // Result register; it also decides when the next character may enter.
    clx_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lex      (lex),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_load     (load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_kind     (kind),
        .o_char     (ch),
        .o_ttype    (ttype),
        .o_last     (o_out.last_result)
    );

    assign o_out.result_kind = kind;
    assign o_out.char_out    = ch;
    assign o_out.token_type  = ttype;

endmodule

// ===== sv/clx_checker.sv =====
// Port-level checks for the command line lexer and the bind that attaches
// them to the top level. Depends on clx_pkg and command_line_lexer.
module clx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_result_kind,
    input logic [7:0] i_char_out,
    input logic [2:0] i_token_type,
    input logic       i_last_result
);
    import clx_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_kind)
            && $stable(i_char_out) && $stable(i_token_type) && $stable(i_last_result))
        else $error("stalled result changed");

    // No new character enters while results of the previous one remain.
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !(i_out_ready && i_last_result) |-> !i_in_ready)
        else $error("input accepted while results still pending");

    // Completions carry no character; characters and errors carry no type.
    a_field_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_result_kind == KIND_DONE) ? (i_char_out == CH_NUL)
                                                      : (i_token_type == TT_IDENT)))
        else $error("result fields inconsistent with result kind");

endmodule

bind command_line_lexer clx_checker u_clx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_result_kind (o_out.result_kind),
    .i_char_out    (o_out.char_out),
    .i_token_type  (o_out.token_type),
    .i_last_result (o_out.last_result)
);

// ===== test/lex_check_pkg.sv =====
`timescale 1ns / 1ps
// Expected-result bookkeeping for the command line lexer testbench: a mode mirror
// that predicts the result items of each accepted character, and their in-order check.
// Depends on clx_pkg for the result field types and character constants.
package lex_check_pkg;

    import clx_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_WORD,
        M_INT,
        M_FRAC,
        M_QUOTED,
        M_PATH,
        M_DASH
    } t_lex_mode;

    typedef struct packed {
        t_kind  kind;
        t_char  ch;
        t_ttype tt;
        logic   last;
    } t_due;

    class lex_result_book;
        t_lex_mode mode;
        t_due      due_results[$];
        t_due      batch[$];
        int        fault_count;

        function new();
            mode        = M_IDLE;
            fault_count = 0;
        endfunction

        local function bit alpha(t_char c);
            return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        endfunction

        local function bit numeral(t_char c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        local function bit blank(t_char c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        local function t_char fold(t_char c);
            return (c >= CH_UP_A && c <= CH_UP_Z) ? t_char'(c + CaseDelta) : c;
        endfunction

        local function void emit(t_kind k, t_char c, t_ttype t);
            t_due d;
            d.kind = k;
            d.ch   = c;
            d.tt   = t;
            d.last = 1'b0;
            batch.push_back(d);
        endfunction

        // A character seen with no token open, either fresh or handed back
        // by a token that it ended.
        local function void from_idle(t_char c);
            if (alpha(c) || c == CH_STAR || c == CH_QUEST) begin
                mode = M_WORD;
                emit(KIND_CHAR, fold(c), TT_IDENT);
            end else if (numeral(c)) begin
                mode = M_INT;
                emit(KIND_CHAR, c, TT_IDENT);
            end else if (c == CH_QUOTE) begin
                mode = M_QUOTED;
            end else if (c == CH_SLASH || c == CH_DOT) begin
                mode = M_PATH;
                emit(KIND_CHAR, c, TT_IDENT);
            end else if (blank(c)) begin
                mode = M_IDLE;
            end else if (c == CH_DASH) begin
                mode = M_DASH;
                emit(KIND_CHAR, c, TT_IDENT);
            end else if (c == CH_EQ) begin
                emit(KIND_CHAR, c, TT_IDENT);
                emit(KIND_DONE, CH_NUL, TT_EQUALS);
            end else begin
                emit(KIND_ERR, c, TT_IDENT);
            end
        endfunction

        // Queues the results of one accepted character. Returns 1 when the
        // character did something: gave a result or moved the mode.
        function bit take_char(logic first, t_char c);
            t_lex_mode prior;
            prior = mode;
            batch.delete();
            if (first) mode = M_IDLE;
            case (mode)
                M_WORD: begin
                    if (alpha(c) || numeral(c) || c == CH_USCORE || c == CH_DOT ||
                        c == CH_STAR) begin
                        emit(KIND_CHAR, fold(c), TT_IDENT);
                    end else begin
                        emit(KIND_DONE, CH_NUL, TT_IDENT);
                        mode = M_IDLE;
                        from_idle(c);
                    end
                end
                M_INT: begin
                    if (numeral(c)) begin
                        emit(KIND_CHAR, c, TT_IDENT);
                    end else if (c == CH_DOT) begin
                        mode = M_FRAC;
                        emit(KIND_CHAR, c, TT_IDENT);
                    end else if (alpha(c)) begin
                        mode = M_WORD;
                        emit(KIND_CHAR, c, TT_IDENT);
                    end else begin
                        emit(KIND_DONE, CH_NUL, TT_NUMBER);
                        mode = M_IDLE;
                        from_idle(c);
                    end
                end
                M_FRAC: begin
                    if (numeral(c)) begin
                        emit(KIND_CHAR, c, TT_IDENT);
                    end else begin
                        emit(KIND_DONE, CH_NUL, TT_NUMBER);
                        mode = M_IDLE;
                        from_idle(c);
                    end
                end
                M_QUOTED: begin
                    if (c != CH_QUOTE) begin
                        emit(KIND_CHAR, c, TT_IDENT);
                    end else begin
                        emit(KIND_DONE, CH_NUL, TT_STRING);
                        mode = M_IDLE;
                    end
                end
                M_PATH: begin
                    if (!blank(c)) begin
                        emit(KIND_CHAR, c, TT_IDENT);
                    end else begin
                        emit(KIND_DONE, CH_NUL, TT_PATH);
                        mode = M_IDLE;
                    end
                end
                M_DASH: begin
                    if (numeral(c)) begin
                        mode = M_INT;
                        emit(KIND_CHAR, c, TT_IDENT);
                    end else if (alpha(c)) begin
                        emit(KIND_DONE, CH_NUL, TT_DASH);
                        mode = M_IDLE;
                        from_idle(c);
                    end
                end
                default: begin
                    mode = M_IDLE;
                    from_idle(c);
                end
            endcase
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) due_results.push_back(batch[i]);
            return batch.size() > 0 || mode != prior;
        endfunction

        function void note_fault(string what);
            fault_count++;
            if (fault_count <= 10) $display("mismatch: %s", what);
        endfunction

        function void match_result(t_kind k, t_char c, t_ttype t, logic last);
            t_due want;
            if (due_results.size() == 0) begin
                note_fault($sformatf("unexpected result kind=%0d ch=%02h tt=%0d last=%0b",
                                     k, c, t, last));
                return;
            end
            want = due_results.pop_front();
            if (want.kind !== k || want.ch !== c || want.tt !== t || want.last !== last)
                note_fault($sformatf({"expected kind=%0d ch=%02h tt=%0d last=%0b, ",
                                      "got kind=%0d ch=%02h tt=%0d last=%0b"},
                                     want.kind, want.ch, want.tt, want.last,
                                     k, c, t, last));
        endfunction

        function void close_out();
            if (due_results.size() != 0)
                note_fault($sformatf("%0d expected results never arrived",
                                     due_results.size()));
        endfunction
    endclass

endpackage

// ===== test/command_line_lexer_tb.sv =====
`timescale 1ns / 1ps
// Testbench of command_line_lexer: directed and random command lines, random idling on
// both channels, every result item checked in order. Depends on clx_pkg, lex_check_pkg,
// clx_in_if, clx_out_if and the lexer RTL.
module command_line_lexer_tb;

    import clx_pkg::*;
    import lex_check_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int RandomItems = 260;

    logic i_clk;
    logic i_rst_n;

    clx_in_if  in_ch();
    clx_out_if out_ch();

    command_line_lexer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lex_result_book book = new();

    int    cycle_count = 0;
    int    live_items  = 0;
    int    long_hold   = 0;
    int    stall_left  = 0;
    int    cmd_index   = 0;
    bit    brisk       = 1'b0;
    bit    took        = 1'b1;
    t_char line_chars[$];

    // 10 ns clock, starting low so that the first rising edge comes at 5 ns.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog that ends the run when the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result monitor. Sampling happens in the active region of the rising
    // edge, before the block's registers move, so it sees the values that
    // the handshake was decided on.
    always @(posedge i_clk) begin
        took = out_ch.valid && out_ch.ready;
        if (took)
            book.match_result(t_kind'(out_ch.result_kind), out_ch.char_out,
                              t_ttype'(out_ch.token_type), out_ch.last_result);
    end

    // Receiver. After each result item it draws a random stall, or none while brisk
    // is set. A long hold requested by the stimulus overrides the draw and is
    // counted down here, so the sender keeps offering items in the meantime.
    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold > 0) begin
                stall_left = long_hold;
                long_hold  = 0;
            end else if (took) begin
                stall_left = brisk ? 0 : $urandom_range(0, 10);
            end
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Offers one character after a random gap and returns at the falling
    // edge after it was accepted, with valid still high. A following call
    // either lowers valid for its gap or puts up the next item directly.
    task automatic send_char(input logic first, input t_char c);
        int gap;
        gap = brisk ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.first_char = first;
        in_ch.char_code  = c;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (book.take_char(first, c)) live_items++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit opens);
        for (int i = 0; i < s.len(); i++)
            send_char(opens && i == 0, t_char'(s[i]));
    endtask

    // The sender holds back until every predicted result has come out.
    task automatic await_quiet();
        in_ch.valid = 1'b0;
        while (book.due_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_char pick_letter();
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + t_char'($urandom_range(0, 25));
    endfunction

    function automatic t_char pick_digit();
        return CH_ZERO + t_char'($urandom_range(0, 9));
    endfunction

    // Mostly a plain space, sometimes one of the control characters that the
    // lexer also treats as white space.
    function automatic t_char pick_blank();
        return ($urandom_range(0, 3) == 0) ? t_char'($urandom_range(9, 13)) : CH_SPACE;
    endfunction

    // Appends one token of a random kind to the command line being built,
    // usually followed by a separator. Without one, tokens run into each
    // other, which exercises the hand-back of an ending character to idle.
    function automatic void add_token();
        t_char c;
        case ($urandom_range(0, 7))
            0, 1: begin
                line_chars.push_back(($urandom_range(0, 9) == 0) ?
                                     ($urandom_range(0, 1) ? CH_STAR : CH_QUEST) :
                                     pick_letter());
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 5))
                        0:       line_chars.push_back(pick_digit());
                        1:       line_chars.push_back(CH_USCORE);
                        2:       line_chars.push_back(CH_DOT);
                        3:       line_chars.push_back(CH_STAR);
                        default: line_chars.push_back(pick_letter());
                    endcase
                end
            end
            2: begin
                repeat ($urandom_range(1, 3)) line_chars.push_back(pick_digit());
                if ($urandom_range(0, 1)) begin
                    line_chars.push_back(CH_DOT);
                    repeat ($urandom_range(0, 2)) line_chars.push_back(pick_digit());
                end
                // A letter right after the number turns an integer into a word and ends a fraction.
                if ($urandom_range(0, 4) == 0) line_chars.push_back(pick_letter());
            end
            3: begin
                line_chars.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    c = t_char'($urandom_range(0, 255));
                    line_chars.push_back((c == CH_QUOTE) ? CH_SPACE : c);
                end
                line_chars.push_back(CH_QUOTE);
            end
            4: begin
                line_chars.push_back($urandom_range(0, 1) ? CH_SLASH : CH_DOT);
                repeat ($urandom_range(1, 6))
                    line_chars.push_back(t_char'($urandom_range(33, 255)));
            end
            5: begin
                line_chars.push_back(CH_DASH);
                // Punctuation after a dash is skipped by the lexer.
                if ($urandom_range(0, 3) == 0)
                    line_chars.push_back(t_char'($urandom_range(33, 47)));
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 3)) line_chars.push_back(pick_digit());
                end else begin
                    repeat ($urandom_range(1, 5)) line_chars.push_back(pick_letter());
                end
            end
            6: line_chars.push_back(CH_EQ);
            default: line_chars.push_back(t_char'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 4) != 0) line_chars.push_back(pick_blank());
    endfunction

    // One command line with the trailing space the host appends. Now and
    // then the line is cut short, so the next command's first character has
    // to abandon a half-built token.
    task automatic send_command();
        int cut;
        line_chars.delete();
        repeat ($urandom_range(1, 5)) add_token();
        line_chars.push_back(CH_SPACE);
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, line_chars.size());
            while (line_chars.size() > cut) void'(line_chars.pop_back());
        end
        foreach (line_chars[i]) send_char(i == 0, line_chars[i]);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_char($urandom_range(0, 3) == 0, t_char'($urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.first_char = 1'b0;
        in_ch.char_code  = CH_NUL;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. The first line walks a word that starts with '?' and
        // lowers 'A', ends it with '=' (three results from one character),
        // turns an integer into a word with an unlowered letter, builds a
        // fraction and lets '/' end the number and open a path.
        send_text("?A_9*=7K 1.5/", 1'b1);
        // A top-bit character inside a path, and a tab to close it.
        send_char(1'b0, 8'hFF);
        send_char(1'b0, CH_TAB);
        // Empty string, a dash that skips punctuation and ends on a letter,
        // then a dash that becomes a number.
        send_text("\"\"-!b-3", 1'b0);
        // First-character flag while a number is open: the number is dropped
        // and the NUL is an error in idle mode, as is 0xFF.
        send_char(1'b1, CH_NUL);
        send_char(1'b0, 8'hFF);
        // A path opened by a dot.
        send_text(". ", 1'b0);
        await_quiet();

        // Random part: mostly well-formed command lines, some noise.
        live_items = 0;
        while (live_items < RandomItems) begin
            cmd_index++;
            // Long receiver hold while the sender streams without gaps, so
            // the result register fills and the input stalls.
            if (cmd_index == 6) begin
                long_hold = 60;
                brisk     = 1'b1;
            end
            if (cmd_index == 9) brisk = 1'b0;
            if (cmd_index == 15) await_quiet();
            // A stretch with no idling on either side.
            if (cmd_index == 25) brisk = 1'b1;
            if (cmd_index == 30) brisk = 1'b0;
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_command();
        end

        await_quiet();
        repeat (8) @(negedge i_clk);
        book.close_out();
        if (book.fault_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/clx_pkg.sv
sv/clx_in_if.sv
sv/clx_out_if.sv
sv/clx_core.sv
sv/clx_outbuf.sv
sv/command_line_lexer.sv
sv/clx_checker.sv
test/lex_check_pkg.sv
test/command_line_lexer_tb.sv
